// ===== rtl/trag_pkg.sv =====
// ---------------------------------------------------------------------------
// trag_pkg
// Shared constants, register codes and control types for the tensor
// reverse address generator.
// ---------------------------------------------------------------------------
package trag_pkg;

	localparam int MAX_DIMS_DEF  = 6;
	localparam int DIM_BITS_DEF  = 12;
	localparam int ADDR_BITS_DEF = 24;
	localparam int DATA_BITS_DEF = 32;

	localparam int SIZE_REGS  = 6;
	localparam int RANK_REG_W = 3;
	localparam int SIZE_REG_W = 13;
	localparam int MASK_W     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK = 3'd0,
		REG_DIM0 = 3'd1,
		REG_DIM1 = 3'd2,
		REG_DIM2 = 3'd3,
		REG_DIM3 = 3'd4,
		REG_DIM4 = 3'd5,
		REG_DIM5 = 3'd6,
		REG_MASK = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic clear;
	} trag_ctrl_t;

endpackage

// ===== rtl/trag_in_if.sv =====
// ---------------------------------------------------------------------------
// trag_in_if
// Element request channel: valid/ready with the raw element value.
// ---------------------------------------------------------------------------
interface trag_in_if #(
	parameter int DATA_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] element_in;

	modport source (output valid, output element_in, input ready);
	modport sink (input valid, input element_in, output ready);
endinterface

// ===== rtl/trag_out_if.sv =====
// ---------------------------------------------------------------------------
// trag_out_if
// Result request channel: destination address, element and flags.
// ---------------------------------------------------------------------------
interface trag_out_if #(
	parameter int ADDR_BITS = 24,
	parameter int DATA_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] dest_addr;
	logic [DATA_BITS-1:0] element_out;
	logic                 last_element;
	logic                 too_large;

	modport source (output valid, output dest_addr, output element_out,
		output last_element, output too_large, input ready);
	modport sink (input valid, input dest_addr, input element_out,
		input last_element, input too_large, output ready);
endinterface

// ===== rtl/trag_derive.sv =====
// ---------------------------------------------------------------------------
// trag_derive
// Configuration registers and a sequencer that walks the dimensions from
// innermost to outermost, one multiply per dimension, to build the address
// step taken when each dimension advances, the start address and the
// overflow flag.
// ---------------------------------------------------------------------------
module trag_derive #(
	parameter int MAX_DIMS  = trag_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS  = trag_pkg::DIM_BITS_DEF,
	parameter int ADDR_BITS = trag_pkg::ADDR_BITS_DEF,
	localparam int RANK_W   = $clog2(MAX_DIMS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [trag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trag_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	output trag_pkg::trag_ctrl_t            ctrl,
	output logic [RANK_W-1:0]               eff_rank,
	output logic [DIM_BITS-1:0]             size_m1 [MAX_DIMS],
	output logic [ADDR_BITS-1:0]            delta [MAX_DIMS],
	output logic [ADDR_BITS-1:0]            base,
	output logic                            too_large
);
	import trag_pkg::*;

	localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int SZ_W      = DIM_BITS + 1;
	localparam int EXT_W     = (SZ_W > SIZE_REG_W) ? SZ_W : SIZE_REG_W;
	localparam int S_W       = ADDR_BITS + 1;
	localparam int PROD_W    = S_W + SZ_W;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC} seq_state_t;

	logic [RANK_REG_W-1:0] rank_q;
	logic [SIZE_REG_W-1:0] size_q [SIZE_REGS];
	logic [MASK_W-1:0]     mask_q;

	logic [SZ_W-1:0]       eff_size [MAX_DIMS];
	logic                  rev_vec [MAX_DIMS];

	seq_state_t            state_q;
	logic [DIM_IDX_W-1:0]  dim_q;
	logic [S_W-1:0]        s_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  ovf_q;
	logic [ADDR_BITS-1:0]  acc_q;
	logic [ADDR_BITS-1:0]  base_q;
	logic [ADDR_BITS-1:0]  delta_q [MAX_DIMS];

	logic                  active;
	logic                  rev;
	logic [ADDR_BITS-1:0]  stride;
	logic [ADDR_BITS-1:0]  span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_REG_W'(1);
			for (int i = 0; i < SIZE_REGS; i++) begin
				size_q[i] <= SIZE_REG_W'(1);
			end
			mask_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RANK: rank_q    <= cfg_wr_data[RANK_REG_W-1:0];
				REG_DIM0: size_q[0] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_DIM1: size_q[1] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_DIM2: size_q[2] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_DIM3: size_q[3] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_DIM4: size_q[4] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_DIM5: size_q[5] <= cfg_wr_data[SIZE_REG_W-1:0];
				REG_MASK: mask_q    <= cfg_wr_data[MASK_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (rank_q == '0) begin
			eff_rank = RANK_W'(1);
		end else if ({1'b0, rank_q} > (RANK_REG_W + 1)'(MAX_DIMS)) begin
			eff_rank = RANK_W'(MAX_DIMS);
		end else begin
			eff_rank = RANK_W'(rank_q);
		end
	end

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
		if (k < SIZE_REGS) begin : g_reg
			logic [EXT_W-1:0] v_ext;
			logic [EXT_W-1:0] lim;
			assign v_ext = EXT_W'(size_q[k]);
			assign lim   = EXT_W'(1) << DIM_BITS;
			assign eff_size[k] = (v_ext == '0) ? SZ_W'(1) :
				(v_ext > lim) ? SZ_W'(lim) : SZ_W'(v_ext);
		end else begin : g_one
			assign eff_size[k] = SZ_W'(1);
		end
		if (k < MASK_W) begin : g_mask
			assign rev_vec[k] = mask_q[k];
		end else begin : g_nomask
			assign rev_vec[k] = 1'b0;
		end
		assign size_m1[k] = DIM_BITS'(eff_size[k] - SZ_W'(1));
		assign delta[k]   = delta_q[k];
	end

	assign active = RANK_W'(dim_q) < eff_rank;
	assign rev    = rev_vec[dim_q];
	assign stride = s_q[ADDR_BITS-1:0];
	assign span   = prod_q[ADDR_BITS-1:0] - stride;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MUL;
			dim_q   <= DIM_IDX_W'(MAX_DIMS - 1);
			s_q     <= S_W'(1);
			ovf_q   <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
		end else if (cfg_wr_en) begin
			state_q <= S_MUL;
			dim_q   <= DIM_IDX_W'(MAX_DIMS - 1);
			s_q     <= S_W'(1);
			ovf_q   <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (active) begin
						acc_q  <= rev ? acc_q + span : acc_q - span;
						base_q <= rev ? base_q + span : base_q;
						s_q    <= prod_q[S_W-1:0];
						ovf_q  <= ovf_q | (prod_q > (PROD_W'(1) << ADDR_BITS));
					end
					if (dim_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						dim_q   <= dim_q - DIM_IDX_W'(1);
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(s_q) * PROD_W'(eff_size[dim_q]);
		end
		if (state_q == S_ACC && !cfg_wr_en) begin
			delta_q[dim_q] <= active ? ((rev ? -stride : stride) + acc_q) : '0;
		end
	end

	assign ctrl.busy  = state_q != S_IDLE;
	assign ctrl.clear = cfg_wr_en;
	assign base       = base_q;
	assign too_large  = ovf_q;

endmodule

// ===== rtl/trag_walk.sv =====
// ---------------------------------------------------------------------------
// trag_walk
// Coordinate counters and running destination address. Each accepted
// element advances the innermost dimension that has not reached its end
// and adds that dimension's address step; after the last element the walk restarts.
// ---------------------------------------------------------------------------
module trag_walk #(
	parameter int MAX_DIMS  = trag_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS  = trag_pkg::DIM_BITS_DEF,
	parameter int ADDR_BITS = trag_pkg::ADDR_BITS_DEF,
	localparam int RANK_W   = $clog2(MAX_DIMS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trag_pkg::trag_ctrl_t ctrl,
	input  logic                 advance,
	input  logic [RANK_W-1:0]    eff_rank,
	input  logic [DIM_BITS-1:0]  size_m1 [MAX_DIMS],
	input  logic [ADDR_BITS-1:0] delta [MAX_DIMS],
	input  logic [ADDR_BITS-1:0] base,
	output logic [ADDR_BITS-1:0] cur_addr,
	output logic                 cur_last
);
	import trag_pkg::*;

	localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	logic [DIM_BITS-1:0]  coord_q [MAX_DIMS];
	logic [ADDR_BITS-1:0] addr_q;
	logic                 fresh_q;

	logic                 at_max [MAX_DIMS];
	logic                 hit;
	logic [DIM_IDX_W-1:0] step_dim;

	always_comb begin
		hit      = 1'b0;
		step_dim = '0;
		for (int k = 0; k < MAX_DIMS; k++) begin
			at_max[k] = (RANK_W'(k) >= eff_rank) || (coord_q[k] == size_m1[k]);
			if (!at_max[k]) begin
				hit      = 1'b1;
				step_dim = DIM_IDX_W'(k);
			end
		end
	end

	assign cur_addr = fresh_q ? base : addr_q;
	assign cur_last = !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIMS; k++) begin
				coord_q[k] <= '0;
			end
			fresh_q <= 1'b1;
		end else if (ctrl.clear) begin
			for (int k = 0; k < MAX_DIMS; k++) begin
				coord_q[k] <= '0;
			end
			fresh_q <= 1'b1;
		end else if (advance) begin
			for (int k = 0; k < MAX_DIMS; k++) begin
				if (!hit || DIM_IDX_W'(k) > step_dim) begin
					coord_q[k] <= '0;
				end else if (DIM_IDX_W'(k) == step_dim) begin
					coord_q[k] <= coord_q[k] + DIM_BITS'(1);
				end
			end
			fresh_q <= !hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			addr_q <= cur_addr + delta[step_dim];
		end
	end

endmodule

// ===== rtl/tensor_reverse_address_gen.sv =====
// ---------------------------------------------------------------------------
// tensor_reverse_address_gen
// Destination address generator for reversing a tensor along a set of axes.
//
//   channel   dir   payload                                         width
//   data_in   in    element_in                                      DATA_BITS
//   result    out   dest_addr, element_out, last_element, too_large A+D+2
//   cfg       in    cfg_wr_en, cfg_index, cfg_wr_data               1+3+13
//
// One element per cycle while ready; result in the cycle after its request.
// The result register frees itself when taken, so data_in stays ready while
// result.ready is high, or while the register is empty.
// After reset and every register write the step sequencer does one multiply
// per dimension in S_MUL, then S_ACC; data_in is not ready then.
// A register write restarts the coordinates at the first element.
// ---------------------------------------------------------------------------
module tensor_reverse_address_gen #(
	parameter int MAX_DIMS  = trag_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS  = trag_pkg::DIM_BITS_DEF,
	parameter int ADDR_BITS = trag_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = trag_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	trag_in_if.sink                         data_in,
	trag_out_if.source                      result,
	input  logic                            cfg_wr_en,
	input  logic [trag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trag_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import trag_pkg::*;

	localparam int RANK_W = $clog2(MAX_DIMS + 1);

	trag_ctrl_t           ctrl;
	logic [RANK_W-1:0]    eff_rank;
	logic [DIM_BITS-1:0]  size_m1 [MAX_DIMS];
	logic [ADDR_BITS-1:0] delta [MAX_DIMS];
	logic [ADDR_BITS-1:0] base;
	logic                 too_large;
	logic [ADDR_BITS-1:0] cur_addr;
	logic                 cur_last;
	logic                 accept;

	logic                 valid_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [DATA_BITS-1:0] elem_s1;
	logic                 last_s1;
	logic                 large_s1;

	trag_derive #(
		.MAX_DIMS  (MAX_DIMS),
		.DIM_BITS  (DIM_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_derive (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.ctrl        (ctrl),
		.eff_rank    (eff_rank),
		.size_m1     (size_m1),
		.delta       (delta),
		.base        (base),
		.too_large   (too_large)
	);

	trag_walk #(
		.MAX_DIMS  (MAX_DIMS),
		.DIM_BITS  (DIM_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.advance  (accept),
		.eff_rank (eff_rank),
		.size_m1  (size_m1),
		.delta    (delta),
		.base     (base),
		.cur_addr (cur_addr),
		.cur_last (cur_last)
	);

	assign data_in.ready = !ctrl.busy && (!valid_s1 || result.ready);
	assign accept        = data_in.valid && data_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (result.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= cur_addr;
			elem_s1  <= data_in.element_in;
			last_s1  <= cur_last;
			large_s1 <= too_large;
		end
	end

	assign result.valid        = valid_s1;
	assign result.dest_addr    = addr_s1;
	assign result.element_out  = elem_s1;
	assign result.last_element = last_s1;
	assign result.too_large    = large_s1;

endmodule

// ===== rtl/trag_checker.sv =====
// ---------------------------------------------------------------------------
// trag_port_checker
// Port-level checks for the tensor reverse address generator.
// ---------------------------------------------------------------------------
module trag_port_checker #(
	parameter int ADDR_BITS = trag_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = trag_pkg::DATA_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ADDR_BITS-1:0] out_addr,
	input logic [DATA_BITS-1:0] out_elem,
	input logic                 cfg_wr_en
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(out_elem))
		else $error("stalled result changed");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !in_ready)
		else $error("request taken while steps are rebuilt");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request gave no result");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready)
		else $error("ready while result register is blocked");

endmodule

bind tensor_reverse_address_gen trag_port_checker #(
	.ADDR_BITS (ADDR_BITS),
	.DATA_BITS (DATA_BITS)
) u_trag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_in.valid),
	.in_ready  (data_in.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_addr  (result.dest_addr),
	.out_elem  (result.element_out),
	.cfg_wr_en (cfg_wr_en)
);
